### hdl/array_priority_queue_defines.svh
// Assertion macros used by the checker file.
// Each macro expects signals named clk and rst_n in the scope where it is used.
`ifndef ARRAY_PRIORITY_QUEUE_DEFINES_SVH
`define ARRAY_PRIORITY_QUEUE_DEFINES_SVH

// Same-cycle implication, disabled during reset
`define APQ_ASSERT_IMPLY(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("array_priority_queue: same-cycle check failed");

// Next-cycle implication, disabled during reset
`define APQ_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("array_priority_queue: next-cycle check failed");

`endif

### hdl/apq_pkg.sv
`default_nettype none

package apq_pkg;

    // One stored job entry, id in the top bits
    typedef struct packed {
        logic [15:0] id;
        logic [7:0]  prio;
        logic [15:0] burst;
    } entry_t;

    typedef enum logic {
        OP_INSERT = 1'b0,
        OP_REMOVE = 1'b1
    } op_t;

    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_OVERFLOW  = 2'd1,
        ST_UNDERFLOW = 2'd2
    } status_t;

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_SHIFT,
        S_FINISH
    } state_t;

endpackage

`default_nettype wire

### hdl/apq_if.sv
`default_nettype none

// Request channel: one queue operation per transfer
interface apq_req_if;
    logic        valid;
    logic        ready;
    logic        operation;
    logic [15:0] job_id;
    logic [7:0]  job_priority;
    logic [15:0] job_burst;

    modport source (output valid, output operation, output job_id, output job_priority,
                    output job_burst, input ready);
    modport sink   (input valid, input operation, input job_id, input job_priority,
                    input job_burst, output ready);
endinterface

// Response channel: one result per request
interface apq_rsp_if;
    logic        valid;
    logic        ready;
    logic [1:0]  status;
    logic [15:0] out_id;
    logic [7:0]  out_priority;
    logic [15:0] out_burst;
    logic [4:0]  occupancy;

    modport source (output valid, output status, output out_id, output out_priority,
                    output out_burst, output occupancy, input ready);
    modport sink   (input valid, input status, input out_id, input out_priority,
                    input out_burst, input occupancy, output ready);
endinterface

`default_nettype wire

### hdl/array_priority_queue.sv
// Bounded priority queue of job entries held in insertion order.
// Channel req carries one operation per transfer: insert (id, priority, burst)
// or remove the entry of highest priority, the earliest one on equal priority.
// Channel rsp returns exactly one result per request: status, the removed
// entry (zero unless a remove succeeded) and the entry count afterwards.
// Entries live in a single-port-read, single-port-write RAM with a registered
// read; one operation is processed at a time.
// A remove first scans the held entries, the scan reading one entry per cycle;
// the gap closure then moves one entry per cycle through the same RAM.
// The next request is taken the cycle after the result is loaded.
// A result waiting on a stalled receiver sits in the output register; the
// next request is still accepted and processed, and its result waits until
// the output register is taken.
// Reset empties the queue (count to zero, no result pending); RAM contents
// are left as they are and never read before being written.
`default_nettype none

module array_priority_queue #(
    parameter int DEPTH = 16
) (
    input  wire        clk,
    input  wire        rst_n,
    apq_req_if.sink    req,
    apq_rsp_if.source  rsp
);

    localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam int CMP_W = CNT_W + 1;

    // Entry RAM
    apq_pkg::entry_t mem [DEPTH];

    logic             mem_we;
    logic [IDX_W-1:0] mem_waddr;
    apq_pkg::entry_t  mem_wdata;
    logic             mem_re;
    logic [IDX_W-1:0] mem_raddr;
    apq_pkg::entry_t  rdata_reg;

    apq_pkg::state_t  state_reg, state_next;
    logic [CNT_W-1:0] count_reg, count_next;
    apq_pkg::op_t     op_reg, op_next;
    apq_pkg::status_t status_reg, status_next;
    logic [IDX_W-1:0] rd_idx_reg, rd_idx_next;
    logic [IDX_W-1:0] best_idx_reg, best_idx_next;
    apq_pkg::entry_t  best_reg, best_next;
    logic [IDX_W-1:0] wr_ptr_reg, wr_ptr_next;

    logic             out_valid_reg, out_valid_next;
    apq_pkg::status_t out_status_reg, out_status_next;
    apq_pkg::entry_t  out_entry_reg, out_entry_next;
    logic [4:0]       out_occ_reg, out_occ_next;

    // Decoded conditions
    logic             req_fire;
    apq_pkg::op_t     req_op;
    logic             is_full;
    logic             is_empty;
    logic             take;
    apq_pkg::entry_t  best_sel;
    logic [IDX_W-1:0] best_idx_sel;
    logic             scan_last;
    logic             shift_needed;
    logic             shift_more;
    logic             out_free;
    logic             removed;
    logic [CNT_W-1:0] count_after;

    assign req.ready = (state_reg == apq_pkg::S_IDLE);
    assign req_fire  = req.valid && req.ready;
    assign req_op    = apq_pkg::op_t'(req.operation);
    assign is_full   = (count_reg == CNT_W'(DEPTH));
    assign is_empty  = (count_reg == '0);
    assign out_free  = !out_valid_reg || rsp.ready;

    // Keep the running maximum; a later entry wins only on strictly greater priority
    assign take         = (rd_idx_reg == '0) || (rdata_reg.prio > best_reg.prio);
    assign best_sel     = take ? rdata_reg : best_reg;
    assign best_idx_sel = take ? rd_idx_reg : best_idx_reg;
    assign scan_last    = (CMP_W'(rd_idx_reg) + CMP_W'(1)) >= CMP_W'(count_reg);
    assign shift_needed = (CMP_W'(best_idx_sel) + CMP_W'(1)) < CMP_W'(count_reg);
    assign shift_more   = (CMP_W'(wr_ptr_reg) + CMP_W'(2)) < CMP_W'(count_reg);

    assign removed     = (op_reg == apq_pkg::OP_REMOVE) && (status_reg == apq_pkg::ST_OK);
    assign count_after = removed ? (count_reg - CNT_W'(1)) : count_reg;

    // Next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            apq_pkg::S_IDLE:
            begin
                if (req_fire)
                begin
                    if (req_op == apq_pkg::OP_REMOVE && !is_empty)
                        state_next = apq_pkg::S_SCAN;
                    else
                        state_next = apq_pkg::S_FINISH;
                end
            end
            apq_pkg::S_SCAN:
            begin
                if (scan_last)
                    state_next = shift_needed ? apq_pkg::S_SHIFT : apq_pkg::S_FINISH;
            end
            apq_pkg::S_SHIFT:
            begin
                if (!shift_more)
                    state_next = apq_pkg::S_FINISH;
            end
            apq_pkg::S_FINISH:
            begin
                if (out_free)
                    state_next = apq_pkg::S_IDLE;
            end
            default:
            begin
                state_next = apq_pkg::S_IDLE;
            end
        endcase
    end

    // RAM control and datapath
    always_comb
    begin
        mem_we          = 1'b0;
        mem_waddr       = wr_ptr_reg;
        mem_wdata       = rdata_reg;
        mem_re          = 1'b0;
        mem_raddr       = rd_idx_reg;
        count_next      = count_reg;
        op_next         = op_reg;
        status_next     = status_reg;
        rd_idx_next     = rd_idx_reg;
        best_idx_next   = best_idx_reg;
        best_next       = best_reg;
        wr_ptr_next     = wr_ptr_reg;
        out_valid_next  = out_valid_reg && !rsp.ready;
        out_status_next = out_status_reg;
        out_entry_next  = out_entry_reg;
        out_occ_next    = out_occ_reg;

        unique case (state_reg)
            apq_pkg::S_IDLE:
            begin
                if (req_fire)
                begin
                    op_next = req_op;
                    if (req_op == apq_pkg::OP_INSERT)
                    begin
                        // Append behind the held entries
                        if (is_full)
                        begin
                            status_next = apq_pkg::ST_OVERFLOW;
                        end
                        else
                        begin
                            status_next = apq_pkg::ST_OK;
                            mem_we      = 1'b1;
                            mem_waddr   = count_reg[IDX_W-1:0];
                            mem_wdata   = '{id: req.job_id, prio: req.job_priority,
                                            burst: req.job_burst};
                            count_next  = count_reg + CNT_W'(1);
                        end
                    end
                    else if (is_empty)
                    begin
                        status_next = apq_pkg::ST_UNDERFLOW;
                    end
                    else
                    begin
                        // Start the scan at the oldest entry
                        status_next = apq_pkg::ST_OK;
                        mem_re      = 1'b1;
                        mem_raddr   = '0;
                        rd_idx_next = '0;
                    end
                end
            end
            apq_pkg::S_SCAN:
            begin
                best_next     = best_sel;
                best_idx_next = best_idx_sel;
                if (!scan_last)
                begin
                    mem_re      = 1'b1;
                    mem_raddr   = rd_idx_reg + IDX_W'(1);
                    rd_idx_next = rd_idx_reg + IDX_W'(1);
                end
                else if (shift_needed)
                begin
                    // Fetch the entry behind the one taken
                    mem_re      = 1'b1;
                    mem_raddr   = best_idx_sel + IDX_W'(1);
                    wr_ptr_next = best_idx_sel;
                end
            end
            apq_pkg::S_SHIFT:
            begin
                // Move the fetched entry down one place, fetch the next one if any remain
                mem_we    = 1'b1;
                mem_waddr = wr_ptr_reg;
                mem_wdata = rdata_reg;
                if (shift_more)
                begin
                    mem_re      = 1'b1;
                    mem_raddr   = wr_ptr_reg + IDX_W'(2);
                    wr_ptr_next = wr_ptr_reg + IDX_W'(1);
                end
            end
            apq_pkg::S_FINISH:
            begin
                if (out_free)
                begin
                    out_valid_next  = 1'b1;
                    out_status_next = status_reg;
                    out_entry_next  = removed ? best_reg : '0;
                    out_occ_next    = 5'(count_after);
                    count_next      = count_after;
                end
            end
            default:
            begin
                mem_we = 1'b0;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= apq_pkg::S_IDLE;
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        op_reg         <= op_next;
        status_reg     <= status_next;
        rd_idx_reg     <= rd_idx_next;
        best_idx_reg   <= best_idx_next;
        best_reg       <= best_next;
        wr_ptr_reg     <= wr_ptr_next;
        out_status_reg <= out_status_next;
        out_entry_reg  <= out_entry_next;
        out_occ_reg    <= out_occ_next;
    end

    // Entry RAM: registered read; a read never targets the entry written that cycle
    always_ff @(posedge clk)
    begin
        if (mem_we)
            mem[mem_waddr] <= mem_wdata;
        if (mem_re)
            rdata_reg <= mem[mem_raddr];
    end

    assign rsp.valid        = out_valid_reg;
    assign rsp.status       = out_status_reg;
    assign rsp.out_id       = out_entry_reg.id;
    assign rsp.out_priority = out_entry_reg.prio;
    assign rsp.out_burst    = out_entry_reg.burst;
    assign rsp.occupancy    = out_occ_reg;

endmodule

`default_nettype wire

### hdl/apq_checker.sv
`default_nettype none
`include "array_priority_queue_defines.svh"

module apq_checker (
    input wire        clk,
    input wire        rst_n,
    input wire        rsp_valid,
    input wire        rsp_ready,
    input wire [1:0]  status,
    input wire [15:0] out_id,
    input wire [7:0]  out_priority,
    input wire [15:0] out_burst,
    input wire [4:0]  occupancy
);

    logic [46:0] rsp_payload;
    logic        entry_zero;
    logic        is_overflow;
    logic        is_underflow;

    // Gather the result fields
    assign rsp_payload  = {status, out_id, out_priority, out_burst, occupancy};
    assign entry_zero   = (out_id == '0) && (out_priority == '0) && (out_burst == '0);
    assign is_overflow  = rsp_valid && (status == apq_pkg::ST_OVERFLOW);
    assign is_underflow = rsp_valid && (status == apq_pkg::ST_UNDERFLOW);

    // A stalled result holds its payload
    `APQ_ASSERT_NEXT(a_rsp_hold, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_payload))

    // Overflow carries no entry
    `APQ_ASSERT_IMPLY(a_overflow_empty, is_overflow, entry_zero)

    // Underflow only on an empty queue, and carries no entry
    `APQ_ASSERT_IMPLY(a_underflow_empty, is_underflow, occupancy == '0 && entry_zero)

endmodule

bind array_priority_queue apq_checker u_apq_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .rsp_valid    (rsp.valid),
    .rsp_ready    (rsp.ready),
    .status       (rsp.status),
    .out_id       (rsp.out_id),
    .out_priority (rsp.out_priority),
    .out_burst    (rsp.out_burst),
    .occupancy    (rsp.occupancy)
);

`default_nettype wire

### verif/array_priority_queue_test.sv
`timescale 1ns / 100ps

module array_priority_queue_test;

    localparam int QUEUE_DEPTH  = 16;
    localparam int RANDOM_ITEMS = 1225;
    localparam int CYCLE_LIMIT  = 300000;
    localparam int DRAIN_CYCLES = 80;
    localparam int MAX_REPORTS  = 10;

    // One queued request, with the idle cycles to leave before it
    typedef struct {
        apq_pkg::op_t    op;
        apq_pkg::entry_t job;
        int              gap;
    } job_request_t;

    // One predicted result
    typedef struct {
        apq_pkg::status_t status;
        apq_pkg::entry_t  taken;
        logic [4:0]       occupancy;
        bit               removal;
    } queue_result_t;

    logic clk = 1'b0;
    logic rst_n;

    apq_req_if req_ch ();
    apq_rsp_if rsp_ch ();

    array_priority_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_dut (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_ch),
        .rsp   (rsp_ch)
    );

    // Requests waiting to be driven, results waiting to arrive
    job_request_t  job_backlog[$];
    queue_result_t awaited_results[$];

    // Shadow copy of the queue contents
    apq_pkg::entry_t shadow_entries [QUEUE_DEPTH];
    int              shadow_count;

    int cycle_count;
    int accepted_count;
    int results_seen;
    int mismatch_count;
    int overflow_seen;
    int underflow_seen;
    int removals_seen;
    int sink_stall;
    bit steady_sink;

    job_request_t  next_job;
    queue_result_t predicted;
    queue_result_t oldest;

    initial
    begin
        forever #5 clk = ~clk;
    end

    // Apply one operation to the shadow queue and work out its result
    task automatic queue_model_step(input apq_pkg::op_t op, input apq_pkg::entry_t job,
                                    output queue_result_t res);
        int best;
        res.status  = apq_pkg::ST_OK;
        res.taken   = '0;
        res.removal = 1'b0;
        if (op == apq_pkg::OP_INSERT) begin
            if (shadow_count >= QUEUE_DEPTH) begin
                res.status = apq_pkg::ST_OVERFLOW;
            end
            else begin
                shadow_entries[shadow_count] = job;
                shadow_count++;
            end
        end
        else if (shadow_count == 0) begin
            res.status = apq_pkg::ST_UNDERFLOW;
        end
        else begin
            // scan for the largest priority, keep the earliest on a tie
            best = 0;
            for (int i = 1; i < shadow_count; i++) begin
                if (shadow_entries[i].prio > shadow_entries[best].prio)
                    best = i;
            end
            res.taken   = shadow_entries[best];
            res.removal = 1'b1;
            // close the gap
            for (int i = best; i + 1 < shadow_count; i++)
                shadow_entries[i] = shadow_entries[i + 1];
            shadow_count--;
        end
        res.occupancy = shadow_count[4:0];
    endtask

    task automatic add_job(input apq_pkg::op_t op, input logic [15:0] id,
                           input logic [7:0] prio, input logic [15:0] burst, input bit calm);
        job_request_t item;
        item.op        = op;
        item.job.id    = id;
        item.job.prio  = prio;
        item.job.burst = burst;
        item.gap       = calm ? 0 : $urandom_range(0, 4);
        job_backlog.push_back(item);
    endtask

    task automatic build_stimulus();
        int mode;
        bit calm;
        logic [7:0] prio;
        // remove on an empty queue, job fields all ones and ignored
        add_job(apq_pkg::OP_REMOVE, 16'hFFFF, 8'hFF, 16'hFFFF, 1'b0);
        // insert all zeros, take back the only entry, then remove from the empty queue again
        add_job(apq_pkg::OP_INSERT, 16'h0000, 8'h00, 16'h0000, 1'b0);
        add_job(apq_pkg::OP_REMOVE, 16'h1234, 8'h56, 16'h789A, 1'b0);
        add_job(apq_pkg::OP_REMOVE, 16'h0000, 8'h00, 16'h0000, 1'b0);
        // fill to the brim with extremes and equal priorities
        add_job(apq_pkg::OP_INSERT, 16'hFFFF, 8'hFF, 16'hFFFF, 1'b0);
        add_job(apq_pkg::OP_INSERT, 16'h0001, 8'h80, 16'h0001, 1'b1);
        add_job(apq_pkg::OP_INSERT, 16'h0002, 8'h80, 16'h0002, 1'b1);
        add_job(apq_pkg::OP_INSERT, 16'h0003, 8'h00, 16'hFFFF, 1'b0);
        add_job(apq_pkg::OP_INSERT, 16'h0004, 8'hFF, 16'h0000, 1'b0);
        for (int i = 0; i < 11; i++)
            add_job(apq_pkg::OP_INSERT, 16'(16'h1000 + i), 8'(i * 7),
                    16'(~(16'h1000 + i)), 1'b0);
        // overflow, then drain the top four
        add_job(apq_pkg::OP_INSERT, 16'hAAAA, 8'hFF, 16'h5555, 1'b0);
        for (int i = 0; i < 4; i++)
            add_job(apq_pkg::OP_REMOVE, 16'($urandom), 8'($urandom), 16'($urandom), 1'b1);

        // random stretches biased towards filling, draining or neither
        mode = 0;
        calm = 1'b0;
        for (int n = 0; n < RANDOM_ITEMS; n++) begin
            if (n % 50 == 0) begin
                mode = $urandom_range(0, 2);
                calm = ($urandom_range(0, 3) == 0);
            end
            prio = ($urandom_range(0, 1) == 0) ? 8'($urandom_range(0, 3)) : 8'($urandom);
            case (mode)
                0: add_job(($urandom_range(0, 99) < 85) ? apq_pkg::OP_INSERT
                                                        : apq_pkg::OP_REMOVE,
                           16'($urandom), prio, 16'($urandom), calm);
                1: add_job(($urandom_range(0, 99) < 85) ? apq_pkg::OP_REMOVE
                                                        : apq_pkg::OP_INSERT,
                           16'($urandom), prio, 16'($urandom), calm);
                default: add_job(($urandom_range(0, 1) == 0) ? apq_pkg::OP_REMOVE
                                                             : apq_pkg::OP_INSERT,
                                 16'($urandom), prio, 16'($urandom), calm);
            endcase
        end
    endtask

    // Request driver: predict on each transfer, then present the next job
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            req_ch.valid        <= 1'b0;
            req_ch.operation    <= apq_pkg::OP_INSERT;
            req_ch.job_id       <= '0;
            req_ch.job_priority <= '0;
            req_ch.job_burst    <= '0;
        end
        else begin
            if (req_ch.valid && req_ch.ready) begin
                queue_model_step(apq_pkg::op_t'(req_ch.operation),
                                 {req_ch.job_id, req_ch.job_priority, req_ch.job_burst},
                                 predicted);
                awaited_results.push_back(predicted);
                accepted_count++;
            end
            if (!req_ch.valid || req_ch.ready) begin
                if (job_backlog.size() > 0 && job_backlog[0].gap == 0) begin
                    next_job = job_backlog.pop_front();
                    req_ch.valid        <= 1'b1;
                    req_ch.operation    <= next_job.op;
                    req_ch.job_id       <= next_job.job.id;
                    req_ch.job_priority <= next_job.job.prio;
                    req_ch.job_burst    <= next_job.job.burst;
                end
                else begin
                    req_ch.valid <= 1'b0;
                    if (job_backlog.size() > 0)
                        job_backlog[0].gap = job_backlog[0].gap - 1;
                end
            end
        end
    end

    // Result monitor: check each transfer against the oldest prediction
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            rsp_ch.ready <= 1'b0;
            sink_stall    = $urandom_range(0, 4);
        end
        else begin
            if (rsp_ch.valid && rsp_ch.ready) begin
                results_seen++;
                if (awaited_results.size() == 0) begin
                    mismatch_count++;
                    if (mismatch_count <= MAX_REPORTS)
                        $display("unexpected result %0d: nothing awaited", results_seen);
                end
                else begin
                    oldest = awaited_results.pop_front();
                    unique case (oldest.status)
                        apq_pkg::ST_OVERFLOW:  overflow_seen++;
                        apq_pkg::ST_UNDERFLOW: underflow_seen++;
                        default:               if (oldest.removal) removals_seen++;
                    endcase
                    if (rsp_ch.status !== oldest.status ||
                        rsp_ch.out_id !== oldest.taken.id ||
                        rsp_ch.out_priority !== oldest.taken.prio ||
                        rsp_ch.out_burst !== oldest.taken.burst ||
                        rsp_ch.occupancy !== oldest.occupancy) begin
                        mismatch_count++;
                        if (mismatch_count <= MAX_REPORTS)
                            $display({"mismatch on result %0d (expected/actual): status %0d/%0d",
                                      " id %h/%h prio %h/%h burst %h/%h occupancy %0d/%0d"},
                                     results_seen, oldest.status, rsp_ch.status,
                                     oldest.taken.id, rsp_ch.out_id,
                                     oldest.taken.prio, rsp_ch.out_priority,
                                     oldest.taken.burst, rsp_ch.out_burst,
                                     oldest.occupancy, rsp_ch.occupancy);
                    end
                end
                // switch between stalling and steady stretches now and then
                if (results_seen % 128 == 0)
                    steady_sink = ($urandom_range(0, 2) == 0);
                sink_stall = steady_sink ? 0 : $urandom_range(0, 4);
            end
            if (sink_stall == 0) begin
                rsp_ch.ready <= 1'b1;
            end
            else begin
                rsp_ch.ready <= 1'b0;
                sink_stall--;
            end
        end
    end

    // Watchdog
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d results awaited",
                     cycle_count, awaited_results.size());
            $display("[array_priority_queue] ERROR");
            $finish;
        end
    end

    // Reset, stimulus and end of run
    initial
    begin
        rst_n               = 1'b0;
        req_ch.valid        = 1'b0;
        req_ch.operation    = apq_pkg::OP_INSERT;
        req_ch.job_id       = '0;
        req_ch.job_priority = '0;
        req_ch.job_burst    = '0;
        rsp_ch.ready        = 1'b0;
        cycle_count         = 0;
        accepted_count      = 0;
        results_seen        = 0;
        mismatch_count      = 0;
        overflow_seen       = 0;
        underflow_seen      = 0;
        removals_seen       = 0;
        steady_sink         = 1'b0;
        shadow_count        = 0;
        for (int i = 0; i < QUEUE_DEPTH; i++)
            shadow_entries[i] = '0;
        build_stimulus();

        repeat (6) @(posedge clk);
        rst_n <= 1'b1;

        // wait for the backlog to drain and every result to arrive
        while (job_backlog.size() > 0 || req_ch.valid)
            @(posedge clk);
        while (awaited_results.size() > 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (awaited_results.size() > 0) begin
            mismatch_count++;
            $display("%0d results never arrived", awaited_results.size());
        end

        $display("run covered %0d requests and %0d results in %0d cycles",
                 accepted_count, results_seen, cycle_count);
        $display("non-empty removals %0d, overflows %0d, underflows %0d, mismatches %0d",
                 removals_seen, overflow_seen, underflow_seen, mismatch_count);
        if (mismatch_count == 0)
            $display("[array_priority_queue] OK");
        else
            $display("[array_priority_queue] ERROR");
        $finish;
    end

endmodule

### sim.f
+incdir+hdl
hdl/apq_pkg.sv
hdl/apq_if.sv
hdl/array_priority_queue.sv
hdl/apq_checker.sv
verif/array_priority_queue_test.sv
